// ===== hdl/rpd_pkg.sv =====
// ----------------------------------------------------------------------------
// rpd_pkg
// Shared types and constants for the run-length packet decompressor.
// ----------------------------------------------------------------------------
`default_nettype none

package rpd_pkg;

  // Decoder phase of the front end
  typedef enum logic [2:0] {
    PH_HDR_HI,
    PH_HDR_LO,
    PH_CONTROL,
    PH_LITERAL,
    PH_RUNVAL,
    PH_REJECT
  } phase_t;

  // Work kind carried from front to back
  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_LIT,
    CMD_RUN
  } cmd_kind_t;

  // Closing status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OVER  = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;
  localparam logic [1:0] ST_SHORT = 2'd3;

  localparam int unsigned POS_W     = 17;
  localparam int unsigned TOTAL_W   = 22;
  localparam logic [POS_W-1:0]   POS_MAX   = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // Queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  typedef struct packed {
    logic       in_last;
    logic [7:0] in_byte;
  } in_word_t;

  typedef struct packed {
    logic [63:0]        out_bytes;
    logic [3:0]         out_count;
    logic               out_last;
    logic [TOTAL_W-1:0] out_total;
    logic [1:0]         out_status;
  } out_word_t;

  // One queue entry: optional data work, then optional close
  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
    logic [6:0] len;
    logic       close;
    logic [1:0] status;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hdl/rpd_front.sv =====
// ----------------------------------------------------------------------------
// rpd_front
// Parses header and control bytes, tracks stream position, and emits one
// command per input byte that has output work or ends the stream.
// ----------------------------------------------------------------------------
`default_nettype none

module rpd_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             acc,
  input  wire rpd_pkg::in_word_t in_word,
  output logic                  push,
  output rpd_pkg::cmd_t         cmd
);

  rpd_pkg::phase_t                  phase_r, phase_nxt, ph;
  logic [rpd_pkg::POS_W-1:0]        pos_r, pos_nxt;
  logic [15:0]                      decl_r, decl_nxt, decl_n;
  logic [6:0]                       grp_r, grp_nxt, grp_n;
  logic [6:0]                       run_r, run_nxt, run_n;
  logic                             in_win;
  logic [7:0]                       b;
  logic                             last;

  assign b    = in_word.in_byte;
  assign last = in_word.in_last;
  assign in_win = pos_r < {1'b0, decl_r};

  always_comb begin
    ph     = phase_r;
    decl_n = decl_r;
    grp_n  = grp_r;
    run_n  = run_r;
    cmd    = '0;
    cmd.kind = rpd_pkg::CMD_NONE;
    cmd.data = b;

    case (phase_r)
      rpd_pkg::PH_HDR_HI: begin
        decl_n = {b, 8'h00};
        ph     = rpd_pkg::PH_HDR_LO;
      end
      rpd_pkg::PH_HDR_LO: begin
        decl_n = {decl_r[15:8], b};
        ph = ({decl_r[15:8], b} < 16'd2) ? rpd_pkg::PH_REJECT : rpd_pkg::PH_CONTROL;
      end
      rpd_pkg::PH_CONTROL: begin
        // control byte in the final slot is a no-op
        if (in_win && (pos_r != ({1'b0, decl_r} - 17'd1)) && !last) begin
          if (!b[7]) begin
            grp_n = b[6:0];
            if (b[6:0] != 7'd0) ph = rpd_pkg::PH_LITERAL;
          end else begin
            run_n = b[6:0];
            ph    = rpd_pkg::PH_RUNVAL;
          end
        end
      end
      rpd_pkg::PH_LITERAL: begin
        if (in_win) begin
          cmd.kind = rpd_pkg::CMD_LIT;
          grp_n    = grp_r - 7'd1;
          if (grp_n == 7'd0) ph = rpd_pkg::PH_CONTROL;
        end
      end
      rpd_pkg::PH_RUNVAL: begin
        if (in_win) begin
          if (run_r != 7'd0) begin
            cmd.kind = rpd_pkg::CMD_RUN;
            cmd.len  = run_r;
          end
          run_n = 7'd0;
          ph    = rpd_pkg::PH_CONTROL;
        end
      end
      default: ;
    endcase

    cmd.close  = last;
    cmd.status = rpd_pkg::ST_OK;
    if (last) begin
      if (ph == rpd_pkg::PH_HDR_HI || ph == rpd_pkg::PH_HDR_LO || ph == rpd_pkg::PH_REJECT)
        cmd.status = rpd_pkg::ST_BAD;
      else if ({2'b00, decl_n} > ({1'b0, pos_r} + 18'd1))
        cmd.status = rpd_pkg::ST_OVER;
      else if (ph == rpd_pkg::PH_LITERAL || ph == rpd_pkg::PH_RUNVAL)
        cmd.status = rpd_pkg::ST_SHORT;
    end

    push = acc && ((cmd.kind != rpd_pkg::CMD_NONE) || last);

    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    decl_nxt  = decl_r;
    grp_nxt   = grp_r;
    run_nxt   = run_r;
    if (acc) begin
      if (last) begin
        phase_nxt = rpd_pkg::PH_HDR_HI;
        pos_nxt   = '0;
        decl_nxt  = '0;
        grp_nxt   = '0;
        run_nxt   = '0;
      end else begin
        phase_nxt = ph;
        pos_nxt   = (pos_r == rpd_pkg::POS_MAX) ? pos_r : pos_r + 17'd1;
        decl_nxt  = decl_n;
        grp_nxt   = grp_n;
        run_nxt   = run_n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= rpd_pkg::PH_HDR_HI;
      pos_r   <= '0;
      decl_r  <= '0;
      grp_r   <= '0;
      run_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      decl_r  <= decl_nxt;
      grp_r   <= grp_nxt;
      run_r   <= run_nxt;
    end
  end

  // an entry without data work must be a close, or the back end would hang
  assert property (@(posedge clk) disable iff (!rst_n)
    (push && cmd.kind == rpd_pkg::CMD_NONE) |-> cmd.close)
    else $error("rpd_front: empty command pushed");

  // literal phase always has bytes left in the group
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == rpd_pkg::PH_LITERAL) |-> (grp_r != 7'd0))
    else $error("rpd_front: literal phase with empty group");

endmodule

`default_nettype wire

// ===== hdl/rpd_queue.sv =====
// ----------------------------------------------------------------------------
// rpd_queue
// Small command FIFO between the parser and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rpd_queue (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire rpd_pkg::cmd_t wr_cmd,
  input  wire logic     pop,
  output rpd_pkg::cmd_t rd_cmd,
  output logic          full,
  output logic          empty
);

  rpd_pkg::cmd_t                 mem [rpd_pkg::QDEPTH];
  logic [rpd_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [rpd_pkg::QPTR_W:0]      cnt_r, cnt_nxt;

  assign full   = cnt_r == (rpd_pkg::QPTR_W+1)'(rpd_pkg::QDEPTH);
  assign empty  = cnt_r == '0;
  assign rd_cmd = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("rpd_queue: overflow");
  assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("rpd_queue: underflow");

endmodule

`default_nettype wire

// ===== hdl/rpd_back.sv =====
// ----------------------------------------------------------------------------
// rpd_back
// Expands queued commands into output words: literals one byte per word,
// runs split into lane-wide chunks, then the closing word with the total.
// ----------------------------------------------------------------------------
`default_nettype none

module rpd_back #(
  parameter int unsigned LANE_BYTES = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire rpd_pkg::cmd_t head,
  input  wire logic         q_empty,
  output logic              pop,
  output logic              out_valid,
  input  wire logic         out_stall,
  output rpd_pkg::out_word_t out_data
);

  localparam logic [3:0] LW = 4'(LANE_BYTES);

  rpd_pkg::cmd_t               cur_r, cur_nxt, cur, rest;
  logic                        busy_r, busy_nxt;
  logic                        out_valid_r, out_valid_nxt;
  rpd_pkg::out_word_t          out_data_r, out_data_nxt;
  logic [rpd_pkg::TOTAL_W-1:0] total_r, total_nxt, total_add;
  logic [rpd_pkg::TOTAL_W:0]   sum;
  logic                        cur_ok, fire, done;
  logic [3:0]                  cnt;
  logic [63:0]                 word;

  always_comb begin
    cur    = busy_r ? cur_r : head;
    cur_ok = busy_r || !q_empty;
    fire   = cur_ok && (!out_valid_r || !out_stall);

    rest = cur;
    cnt  = 4'd0;
    case (cur.kind)
      rpd_pkg::CMD_LIT: begin
        cnt       = 4'd1;
        rest.kind = rpd_pkg::CMD_NONE;
      end
      rpd_pkg::CMD_RUN: begin
        cnt       = (cur.len < {3'b000, LW}) ? cur.len[3:0] : LW;
        rest.len  = cur.len - {3'b000, cnt};
        rest.kind = (rest.len == 7'd0) ? rpd_pkg::CMD_NONE : rpd_pkg::CMD_RUN;
      end
      default: begin
        rest.close = 1'b0;
      end
    endcase
    done = (rest.kind == rpd_pkg::CMD_NONE) && !rest.close;

    for (int i = 0; i < 8; i++) begin
      word[8*i +: 8] = (4'(i) < cnt) ? cur.data : 8'h00;
    end

    sum       = {1'b0, total_r} + {19'b0, cnt};
    total_add = (sum > {1'b0, rpd_pkg::TOTAL_MAX}) ? rpd_pkg::TOTAL_MAX
                                                   : sum[rpd_pkg::TOTAL_W-1:0];

    out_data_nxt = out_data_r;
    total_nxt    = total_r;
    busy_nxt     = busy_r;
    cur_nxt      = cur_r;
    pop          = fire && !busy_r;
    if (fire) begin
      busy_nxt = !done;
      cur_nxt  = rest;
      if (cur.kind == rpd_pkg::CMD_NONE) begin
        // closing word reports the running total, then the stream restarts
        out_data_nxt.out_bytes  = '0;
        out_data_nxt.out_count  = 4'd0;
        out_data_nxt.out_last   = 1'b1;
        out_data_nxt.out_total  = total_r;
        out_data_nxt.out_status = cur.status;
        total_nxt = '0;
      end else begin
        out_data_nxt.out_bytes  = word;
        out_data_nxt.out_count  = cnt;
        out_data_nxt.out_last   = 1'b0;
        out_data_nxt.out_total  = total_add;
        out_data_nxt.out_status = rpd_pkg::ST_OK;
        total_nxt = total_add;
      end
    end

    out_valid_nxt = fire ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      total_r     <= '0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      total_r     <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    cur_r      <= cur_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // data words never exceed the lane width and are never empty
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.out_last) |->
      (out_data_r.out_count != 4'd0 && out_data_r.out_count <= LW))
    else $error("rpd_back: bad data word count");

  // total restarts after every closing word
  assert property (@(posedge clk) disable iff (!rst_n)
    (fire && cur.kind == rpd_pkg::CMD_NONE) |=> (total_r == '0))
    else $error("rpd_back: total not cleared after close");

endmodule

`default_nettype wire

// ===== hdl/rle_packet_decompressor_top.sv =====
// ----------------------------------------------------------------------------
// rle_packet_decompressor_top
// Path: an accepted byte is parsed combinationally and written to the command
// queue; the back end expands it into registered output words. Throughput:
// one input byte per cycle while the 4-entry command queue has room; a run of
// L bytes makes ceil(L/LANE_BYTES) words, a literal or the close one word.
// Reset: synchronous active-low rst_n; no clearing pass, ready after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module rle_packet_decompressor_top #(
  parameter int unsigned LANE_BYTES = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire rpd_pkg::in_word_t in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output rpd_pkg::out_word_t out_data
);

  rpd_pkg::cmd_t push_cmd, head_cmd;
  logic          push, pop, q_full, q_empty, acc;

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;

  rpd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .in_word (in_data),
    .push    (push),
    .cmd     (push_cmd)
  );

  rpd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_cmd (push_cmd),
    .pop    (pop),
    .rd_cmd (head_cmd),
    .full   (q_full),
    .empty  (q_empty)
  );

  rpd_back #(
    .LANE_BYTES (LANE_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head_cmd),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the run-length packet decompressor. It first runs
// a short table of hand-built streams, then random, mostly well formed streams.
// Words are matched to a local decoder model; table closes use typed fields.
// ----------------------------------------------------------------------------

module tb_top;
  import rpd_pkg::*;

  localparam int unsigned LANE         = 8;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned RANDOM_WORDS = 400;
  localparam int unsigned HOLD_START   = 150;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned REPORT_MAX   = 10;

  // One input word plus, for table rows, the closing fields typed in by hand
  typedef struct packed {
    logic               last;
    logic [7:0]         value;
    logic               known;
    logic [1:0]         status;
    logic [TOTAL_W-1:0] total;
  } stim_row_t;

  localparam stim_row_t DIRECTED [28] = '{
    // header below two: stream rejected, later bytes ignored
    '{1'b0, 8'h00, 1'b0, ST_OK,    22'd0},
    '{1'b0, 8'h01, 1'b0, ST_OK,    22'd0},
    '{1'b1, 8'h41, 1'b1, ST_BAD,   22'd0},
    // stream ends inside the header
    '{1'b1, 8'hFF, 1'b1, ST_BAD,   22'd0},
    // empty literal group, one literal, header past the end of the stream
    '{1'b0, 8'h00, 1'b0, ST_OK,    22'd0},
    '{1'b0, 8'h0A, 1'b0, ST_OK,    22'd0},
    '{1'b0, 8'h00, 1'b0, ST_OK,    22'd0},
    '{1'b0, 8'h01, 1'b0, ST_OK,    22'd0},
    '{1'b1, 8'hAA, 1'b1, ST_OVER,  22'd1},
    // longest run, zero-length run, control byte in the final slot
    '{1'b0, 8'h00, 1'b0, ST_OK,    22'd0},
    '{1'b0, 8'h07, 1'b0, ST_OK,    22'd0},
    '{1'b0, 8'hFF, 1'b0, ST_OK,    22'd0},
    '{1'b0, 8'h00, 1'b0, ST_OK,    22'd0},
    '{1'b0, 8'h80, 1'b0, ST_OK,    22'd0},
    '{1'b0, 8'h77, 1'b0, ST_OK,    22'd0},
    '{1'b1, 8'h7F, 1'b1, ST_OK,    22'd127},
    // control at length-1 is dropped, bytes past the length ignored
    '{1'b0, 8'h00, 1'b0, ST_OK,    22'd0},
    '{1'b0, 8'h05, 1'b0, ST_OK,    22'd0},
    '{1'b0, 8'h01, 1'b0, ST_OK,    22'd0},
    '{1'b0, 8'hFF, 1'b0, ST_OK,    22'd0},
    '{1'b0, 8'h85, 1'b0, ST_OK,    22'd0},
    '{1'b0, 8'h12, 1'b0, ST_OK,    22'd0},
    '{1'b1, 8'h34, 1'b1, ST_OK,    22'd1},
    // literal group cut short by the end of the stream
    '{1'b0, 8'h00, 1'b0, ST_OK,    22'd0},
    '{1'b0, 8'h05, 1'b0, ST_OK,    22'd0},
    '{1'b0, 8'h05, 1'b0, ST_OK,    22'd0},
    '{1'b0, 8'h01, 1'b0, ST_OK,    22'd0},
    '{1'b1, 8'h02, 1'b1, ST_SHORT, 22'd2}
  };

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;

  stim_row_t   sent_row = '0;
  stim_row_t   stim_rows [$];
  out_word_t   expected_words [$];
  int unsigned random_count   = 0;
  int unsigned mismatch_count = 0;
  int unsigned words_checked  = 0;
  int unsigned cycle_count    = 0;
  bit          feed_done      = 1'b0;

  // decoder model state
  phase_t             dec_phase;
  logic [POS_W-1:0]   dec_pos;
  logic [15:0]        dec_size;
  logic [6:0]         dec_group_left;
  logic [6:0]         dec_run_len;
  logic [TOTAL_W-1:0] dec_total;

  rle_packet_decompressor_top #(.LANE_BYTES(LANE)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  task automatic clear_decoder();
    dec_phase      = PH_HDR_HI;
    dec_pos        = '0;
    dec_size       = '0;
    dec_group_left = '0;
    dec_run_len    = '0;
    dec_total      = '0;
  endtask

  task automatic emit_bytes(input logic [63:0] lanes, input int unsigned cnt);
    out_word_t w;
    if (dec_total + cnt > TOTAL_MAX) dec_total = TOTAL_MAX;
    else dec_total = dec_total + cnt;
    w           = '0;
    w.out_bytes = lanes;
    w.out_count = cnt[3:0];
    w.out_total = dec_total;
    expected_words.push_back(w);
  endtask

  task automatic decode_byte(input stim_row_t row);
    int unsigned p;
    int unsigned n;
    int unsigned c;
    int unsigned i;
    logic [63:0] lanes;
    out_word_t   close_word;
    p = dec_pos;
    if (dec_pos != POS_MAX) dec_pos = dec_pos + 1'b1;
    case (dec_phase)
      PH_HDR_HI: begin
        dec_size  = {row.value, 8'h00};
        dec_phase = PH_HDR_LO;
      end
      PH_HDR_LO: begin
        dec_size[7:0] = row.value;
        dec_phase     = (dec_size < 16'd2) ? PH_REJECT : PH_CONTROL;
      end
      PH_CONTROL: begin
        // control in the final slot of the stream does nothing
        if (p < dec_size && p != dec_size - 1 && !row.last) begin
          if (!row.value[7]) begin
            dec_group_left = row.value[6:0];
            if (row.value != 8'h00) dec_phase = PH_LITERAL;
          end else begin
            dec_run_len = row.value[6:0];
            dec_phase   = PH_RUNVAL;
          end
        end
      end
      PH_LITERAL: begin
        if (p < dec_size) begin
          emit_bytes({56'h0, row.value}, 1);
          dec_group_left = dec_group_left - 1'b1;
          if (dec_group_left == 7'd0) dec_phase = PH_CONTROL;
        end
      end
      PH_RUNVAL: begin
        if (p < dec_size) begin
          n = dec_run_len;
          while (n > 0) begin
            c     = (n < LANE) ? n : LANE;
            lanes = '0;
            for (i = 0; i < c; i++) lanes[8*i +: 8] = row.value;
            emit_bytes(lanes, c);
            n = n - c;
          end
          dec_run_len = 7'd0;
          dec_phase   = PH_CONTROL;
        end
      end
      default: ;
    endcase
    if (row.last) begin
      close_word           = '0;
      close_word.out_last  = 1'b1;
      close_word.out_total = dec_total;
      if (dec_phase == PH_HDR_HI || dec_phase == PH_HDR_LO || dec_phase == PH_REJECT)
        close_word.out_status = ST_BAD;
      else if (dec_size > p + 1)
        close_word.out_status = ST_OVER;
      else if (dec_phase == PH_LITERAL || dec_phase == PH_RUNVAL)
        close_word.out_status = ST_SHORT;
      else
        close_word.out_status = ST_OK;
      if (row.known) begin
        close_word.out_status = row.status;
        close_word.out_total  = row.total;
      end
      expected_words.push_back(close_word);
      clear_decoder();
    end
  endtask

  // One random stream: mostly well formed, the rest with a bad header,
  // trailing junk, an early end or pure noise.
  task automatic build_stream();
    logic [7:0]  body [$];
    logic [15:0] hdr;
    int unsigned kind;
    int unsigned n;
    int unsigned keep;
    int unsigned i;
    stim_row_t   row;
    kind = $urandom_range(0, 19);
    repeat ($urandom_range(1, 6)) begin
      if ($urandom_range(0, 1) == 0) begin
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 6);
        body.push_back(8'(n));
        repeat (n) body.push_back(8'($urandom_range(0, 255)));
      end else begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 20);
        body.push_back(8'(128 + n));
        body.push_back(8'($urandom_range(0, 255)));
      end
    end
    hdr  = 16'(body.size() + 2);
    keep = body.size() + 2;
    case (kind)
      14, 15: hdr = 16'(body.size() + 2 + $urandom_range(1, 300));  // header too big
      16: hdr = 16'($urandom_range(2, body.size() + 1));            // junk past length
      17: keep = $urandom_range(1, body.size() + 1);                // early end
      18: hdr = 16'($urandom_range(0, 1));                          // rejected
      19: begin
        body.delete();
        repeat ($urandom_range(0, 12)) body.push_back(8'($urandom_range(0, 255)));
        hdr  = 16'($urandom());
        keep = body.size() + 2;
      end
      default: ;
    endcase
    body.push_front(hdr[7:0]);
    body.push_front(hdr[15:8]);
    for (i = 0; i < keep; i++) begin
      row       = '0;
      row.value = body[i];
      row.last  = (i == keep - 1);
      stim_rows.push_back(row);
    end
    random_count += keep;
  endtask

  // sender
  initial begin : feed
    stim_row_t   row;
    int unsigned gap;
    int unsigned r;
    clear_decoder();
    foreach (DIRECTED[k]) stim_rows.push_back(DIRECTED[k]);
    while (random_count < RANDOM_WORDS) build_stream();
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    while (stim_rows.size() > 0) begin
      row = stim_rows.pop_front();
      r   = $urandom_range(0, 99);
      if (r < 60) gap = 0;
      else if (r < 90) gap = $urandom_range(1, 3);
      else if (r < 98) gap = $urandom_range(4, 10);
      else gap = $urandom_range(20, 50);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data  <= '{in_last: row.last, in_byte: row.value};
      sent_row <= row;
      @(posedge clk);
      while (in_stall) @(posedge clk);
    end
    in_valid  <= 1'b0;
    feed_done = 1'b1;
  end

  // receiver: random stalls, plus one long hold-off so the queue backs up
  initial begin : sink
    int unsigned r;
    int unsigned span;
    int unsigned elapsed;
    bit          held;
    elapsed = 0;
    held    = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && elapsed >= HOLD_START) begin
        held      = 1'b1;
        out_stall <= 1'b1;
        span      = HOLD_CYCLES;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          out_stall <= 1'b0;
          span      = $urandom_range(1, 6);
        end else if (r < 60) begin
          out_stall <= 1'b0;
          span      = $urandom_range(10, 40);
        end else if (r < 95) begin
          out_stall <= 1'b1;
          span      = $urandom_range(1, 3);
        end else begin
          out_stall <= 1'b1;
          span      = $urandom_range(10, 40);
        end
      end
      repeat (span) @(posedge clk);
      elapsed += span;
    end
  end

  // model update on accepted input, then score the accepted output word
  always @(posedge clk) begin : score
    out_word_t want;
    if (rst_n && in_valid && !in_stall) decode_byte(sent_row);
    if (rst_n && out_valid && !out_stall) begin
      words_checked++;
      if (expected_words.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("word %0d unexpected: bytes %h count %0d last %0b total %0d status %0d",
                   words_checked, out_data.out_bytes, out_data.out_count,
                   out_data.out_last, out_data.out_total, out_data.out_status);
      end else begin
        want = expected_words.pop_front();
        if (out_data !== want) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("word %0d mismatch (exp/act): bytes %h/%h count %0d/%0d",
                     words_checked, want.out_bytes, out_data.out_bytes,
                     want.out_count, out_data.out_count,
                     " last %0b/%0b total %0d/%0d status %0d/%0d",
                     want.out_last, out_data.out_last, want.out_total,
                     out_data.out_total, want.out_status, out_data.out_status);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("rle_packet_decompressor_top regression: fail");
      $finish;
    end
  end

  initial begin : finish_run
    wait (feed_done);
    // let the model take in the last accepted word first
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("rle_packet_decompressor_top regression: pass");
    end else begin
      $display("rle_packet_decompressor_top regression: fail");
    end
    $finish;
  end

endmodule
